@@ sv/point_to_line_distance_core_defines.svh @@
// ----------------------------------------------------------------------------
// Point to line distance core: assertion macros
// Shorthand for the concurrent checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_LINE_DISTANCE_CORE_DEFINES_SVH
`define POINT_TO_LINE_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define PTLD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptld: same-cycle check failed");

// Next-cycle implication, live through reset.
`define PTLD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ptld: next-cycle check failed");

`endif

@@ sv/ptld_pkg.sv @@
// ----------------------------------------------------------------------------
// Point to line distance package
// Fixed-point constants and lookup tables for the distance pipeline.
// ----------------------------------------------------------------------------
package ptld_pkg;

    // angle units per full turn (1/256 degree)
    localparam int ANG_TURN      = 92160;
    localparam int MAX_STAGES    = 24;

    // binary angle = round(r * 2^32 / 92160) = q * 2^21 + FRAC_TAB[m], r = 45 q + m
    localparam int FRAC_DIV      = 45;
    localparam int FRAC_W        = 21;
    localparam int QUO_W         = 11;
    localparam int RECIP_SHIFT   = 23;
    localparam logic [17:0] RECIP_MULT = 18'd186414;   // ceil(2^23 / 45)

    localparam int TRIG_ONE_BITS = 30;
    localparam int HALF_Q30      = 536870912;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam int COORD_MAX     = 8388607;
    localparam int COORD_MIN     = -8388608;
    localparam int SDIST_MAX     = 16777215;
    localparam int SDIST_MIN     = -16777216;
    localparam int ADIST_MAX     = 16777215;

    typedef logic [31:0] t_atan_tab [0:MAX_STAGES-1];
    typedef logic [FRAC_W-1:0] t_frac_tab [0:FRAC_DIV-1];

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    localparam t_atan_tab ATAN_TURN = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // floor((m * 2^21 + 22) / 45), built at elaboration
    function automatic t_frac_tab f_frac_tab();
        t_frac_tab tab;
        longint    v;
        for (int m = 0; m < FRAC_DIV; m++) begin
            v = ((longint'(m) <<< FRAC_W) + 64'sd22) / FRAC_DIV;
            tab[m] = FRAC_W'(v);
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = f_frac_tab();

endpackage

@@ sv/point_to_line_distance_core.sv @@
// ----------------------------------------------------------------------------
// Point to line distance core
// Signed perpendicular distance of a point from a line given by an anchor
// point and a direction angle, its magnitude, and the foot of the
// perpendicular. Coordinates are signed fixed point, all in one format; the
// angle is in 1/256 degree and may be anything within the 18-bit range, it is
// reduced modulo one turn. A word is taken whenever start is high (busy is
// tied low: the pipeline never stalls) and one result word leaves on o_done
// for each word taken, one word per cycle sustained. The pipeline is the
// unrolled CORDIC rotator, one micro-rotation per stage, plus four stages of
// angle reduction in front and five stages of multiply, round and saturate
// behind it. The receiver cannot stall, so each result is valid for the
// single cycle that o_done is high and must be captured then. Distances and
// foot coordinates saturate at their port ranges.
// ----------------------------------------------------------------------------
`include "point_to_line_distance_core_defines.svh"

module point_to_line_distance_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [23:0] i_anchor_x,
    input  logic signed [23:0] i_anchor_y,
    input  logic signed [17:0] i_line_angle,
    output logic               o_done,
    output logic        [23:0] o_abs_distance,
    output logic signed [24:0] o_signed_distance,
    output logic signed [23:0] o_foot_x,
    output logic signed [23:0] o_foot_y
);

    // rotator depth, capped at the arctangent table size
    localparam int NSTG = (CORDIC_STAGES > ptld_pkg::MAX_STAGES) ?
                          ptld_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int QW   = ptld_pkg::QUO_W;
    localparam int RS   = ptld_pkg::RECIP_SHIFT;
    localparam int TB   = ptld_pkg::TRIG_ONE_BITS;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: fold the angle into [0, 92160), form P - A
    // ------------------------------------------------------------------
    logic signed [19:0] w_ang, w_ang_p, w_ang_pp, w_ang_m, w_ang_red;

    assign w_ang    = 20'(i_line_angle);
    assign w_ang_p  = w_ang + 20'(ptld_pkg::ANG_TURN);
    assign w_ang_pp = w_ang + 20'(2 * ptld_pkg::ANG_TURN);
    assign w_ang_m  = w_ang - 20'(ptld_pkg::ANG_TURN);

    always_comb begin
        priority if (w_ang < 0 && w_ang_p < 0) begin
            w_ang_red = w_ang_pp;
        end else if (w_ang < 0) begin
            w_ang_red = w_ang_p;
        end else if (w_ang_m >= 0) begin
            w_ang_red = w_ang_m;
        end else begin
            w_ang_red = w_ang;
        end
    end

    logic               r1_vld;
    logic        [16:0] r1_r;
    logic signed [23:0] r1_px, r1_py;
    logic signed [24:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_r  <= w_ang_red[16:0];
        r1_px <= i_point_x;
        r1_py <= i_point_y;
        r1_dx <= 25'(i_point_x) - 25'(i_anchor_x);
        r1_dy <= 25'(i_point_y) - 25'(i_anchor_y);
    end

    // ------------------------------------------------------------------
    // Stage 2: r * ceil(2^23/45), quotient by 45 is the top bits
    // ------------------------------------------------------------------
    logic               r2_vld;
    logic        [34:0] r2_prod;
    logic        [16:0] r2_r;
    logic signed [23:0] r2_px, r2_py;
    logic signed [24:0] r2_dx, r2_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_prod <= 35'(r1_r) * 35'(ptld_pkg::RECIP_MULT);
        r2_r    <= r1_r;
        r2_px   <= r1_px;
        r2_py   <= r1_py;
        r2_dx   <= r1_dx;
        r2_dy   <= r1_dy;
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient and remainder by 45
    // ------------------------------------------------------------------
    logic        [QW-1:0] w_q;
    logic        [16:0]   w_m;

    assign w_q = r2_prod[RS+QW-1:RS];
    assign w_m = r2_r - 17'(w_q) * 17'(ptld_pkg::FRAC_DIV);

    logic               r3_vld;
    logic [QW-1:0]      r3_q;
    logic [5:0]         r3_m;
    logic signed [23:0] r3_px, r3_py;
    logic signed [24:0] r3_dx, r3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_q  <= w_q;
        r3_m  <= w_m[5:0];
        r3_px <= r2_px;
        r3_py <= r2_py;
        r3_dx <= r2_dx;
        r3_dy <= r2_dy;
    end

    // ------------------------------------------------------------------
    // Stage 4 (rotator level 0): binary angle, fold into +/-90 degrees
    // ------------------------------------------------------------------
    logic [31:0]        w_ba;
    logic               w_flip;
    logic signed [31:0] w_z0;

    assign w_ba   = {r3_q, ptld_pkg::FRAC_TAB[r3_m]};
    // ba + 90 deg lands in the upper half: angle in [90, 270)
    assign w_flip = w_ba[31] ^ w_ba[30];
    assign w_z0   = signed'(w_flip ? (w_ba ^ 32'h8000_0000) : w_ba);

    logic               r_lvl_vld [0:NSTG];
    logic signed [31:0] r_lx      [0:NSTG];
    logic signed [31:0] r_ly      [0:NSTG];
    logic signed [31:0] r_lz      [0:NSTG];
    logic               r_lflip   [0:NSTG];
    logic signed [23:0] r_lpx     [0:NSTG];
    logic signed [23:0] r_lpy     [0:NSTG];
    logic signed [24:0] r_ldx     [0:NSTG];
    logic signed [24:0] r_ldy     [0:NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld[0] <= 1'b0;
        end else begin
            r_lvl_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lx[0]    <= ptld_pkg::CORDIC_GAIN;
        r_ly[0]    <= '0;
        r_lz[0]    <= w_z0;
        r_lflip[0] <= w_flip;
        r_lpx[0]   <= r3_px;
        r_lpy[0]   <= r3_py;
        r_ldx[0]   <= r3_dx;
        r_ldy[0]   <= r3_dy;
    end

    // ------------------------------------------------------------------
    // CORDIC rotation, one micro-rotation per stage, floor shifts
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NSTG; k++) begin : g_rot
        logic signed [31:0] w_xs, w_ys, w_at;

        assign w_xs = r_lx[k] >>> k;
        assign w_ys = r_ly[k] >>> k;
        assign w_at = signed'(ptld_pkg::ATAN_TURN[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lvl_vld[k+1] <= 1'b0;
            end else begin
                r_lvl_vld[k+1] <= r_lvl_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!r_lz[k][31]) begin
                r_lx[k+1] <= r_lx[k] - w_ys;
                r_ly[k+1] <= r_ly[k] + w_xs;
                r_lz[k+1] <= r_lz[k] - w_at;
            end else begin
                r_lx[k+1] <= r_lx[k] + w_ys;
                r_ly[k+1] <= r_ly[k] - w_xs;
                r_lz[k+1] <= r_lz[k] + w_at;
            end
            r_lflip[k+1] <= r_lflip[k];
            r_lpx[k+1]   <= r_lpx[k];
            r_lpy[k+1]   <= r_lpy[k];
            r_ldx[k+1]   <= r_ldx[k];
            r_ldy[k+1]   <= r_ldy[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: undo the half-turn fold, cos/sin in Q30
    // ------------------------------------------------------------------
    logic               r5_vld;
    logic signed [31:0] r5_c, r5_s;
    logic signed [23:0] r5_px, r5_py;
    logic signed [24:0] r5_dx, r5_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r_lvl_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_c  <= r_lflip[NSTG] ? -r_lx[NSTG] : r_lx[NSTG];
        r5_s  <= r_lflip[NSTG] ? -r_ly[NSTG] : r_ly[NSTG];
        r5_px <= r_lpx[NSTG];
        r5_py <= r_lpy[NSTG];
        r5_dx <= r_ldx[NSTG];
        r5_dy <= r_ldy[NSTG];
    end

    // ------------------------------------------------------------------
    // Stage 6: s*dx and c*dy
    // ------------------------------------------------------------------
    logic signed [56:0] w_sdx, w_cdy;

    assign w_sdx = r5_s * r5_dx;
    assign w_cdy = r5_c * r5_dy;

    logic               r6_vld;
    logic signed [56:0] r6_sdx, r6_cdy;
    logic signed [31:0] r6_c, r6_s;
    logic signed [23:0] r6_px, r6_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_sdx <= w_sdx;
        r6_cdy <= w_cdy;
        r6_c   <= r5_c;
        r6_s   <= r5_s;
        r6_px  <= r5_px;
        r6_py  <= r5_py;
    end

    // ------------------------------------------------------------------
    // Stage 7: d = round_half_up((c*dy - s*dx) / 2^30)
    // ------------------------------------------------------------------
    logic signed [57:0] w_t, w_t_rnd;
    logic signed [27:0] w_d;

    assign w_t     = 58'(r6_cdy) - 58'(r6_sdx);
    assign w_t_rnd = w_t + 58'(ptld_pkg::HALF_Q30);
    assign w_d     = signed'(w_t_rnd[TB+27:TB]);

    logic               r7_vld;
    logic signed [27:0] r7_d;
    logic signed [31:0] r7_c, r7_s;
    logic signed [23:0] r7_px, r7_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_d  <= w_d;
        r7_c  <= r6_c;
        r7_s  <= r6_s;
        r7_px <= r6_px;
        r7_py <= r6_py;
    end

    // ------------------------------------------------------------------
    // Stage 8: s*d, c*d; saturate both distance outputs from raw d
    // ------------------------------------------------------------------
    logic signed [59:0] w_sdp, w_cdp;
    logic signed [27:0] w_dabs;
    logic signed [24:0] w_sdist;
    logic        [23:0] w_adist;

    assign w_sdp  = r7_s * r7_d;
    assign w_cdp  = r7_c * r7_d;
    assign w_dabs = r7_d[27] ? -r7_d : r7_d;

    always_comb begin
        priority if (r7_d > ptld_pkg::SDIST_MAX) begin
            w_sdist = 25'(ptld_pkg::SDIST_MAX);
        end else if (r7_d < ptld_pkg::SDIST_MIN) begin
            w_sdist = 25'(ptld_pkg::SDIST_MIN);
        end else begin
            w_sdist = r7_d[24:0];
        end
    end

    assign w_adist = (w_dabs > ptld_pkg::ADIST_MAX) ? 24'(ptld_pkg::ADIST_MAX)
                                                    : w_dabs[23:0];

    logic               r8_vld;
    logic signed [59:0] r8_sdp, r8_cdp;
    logic signed [24:0] r8_sdist;
    logic        [23:0] r8_adist;
    logic signed [23:0] r8_px, r8_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_sdp   <= w_sdp;
        r8_cdp   <= w_cdp;
        r8_sdist <= w_sdist;
        r8_adist <= w_adist;
        r8_px    <= r7_px;
        r8_py    <= r7_py;
    end

    // ------------------------------------------------------------------
    // Stage 9: foot = P + (s*d, -c*d) rounded, saturated; output register
    // ------------------------------------------------------------------
    logic signed [59:0] w_sdp_rnd, w_cdp_rnd;
    logic signed [29:0] w_fx_full, w_fy_full;
    logic signed [23:0] w_fx, w_fy;

    assign w_sdp_rnd = r8_sdp + 60'(ptld_pkg::HALF_Q30);
    assign w_cdp_rnd = r8_cdp + 60'(ptld_pkg::HALF_Q30);
    assign w_fx_full = 30'(r8_px) + signed'(w_sdp_rnd[TB+29:TB]);
    assign w_fy_full = 30'(r8_py) - signed'(w_cdp_rnd[TB+29:TB]);

    always_comb begin
        priority if (w_fx_full > ptld_pkg::COORD_MAX) begin
            w_fx = 24'(ptld_pkg::COORD_MAX);
        end else if (w_fx_full < ptld_pkg::COORD_MIN) begin
            w_fx = 24'(ptld_pkg::COORD_MIN);
        end else begin
            w_fx = w_fx_full[23:0];
        end
        priority if (w_fy_full > ptld_pkg::COORD_MAX) begin
            w_fy = 24'(ptld_pkg::COORD_MAX);
        end else if (w_fy_full < ptld_pkg::COORD_MIN) begin
            w_fy = 24'(ptld_pkg::COORD_MIN);
        end else begin
            w_fy = w_fy_full[23:0];
        end
    end

    logic               r_done;
    logic        [23:0] r_abs;
    logic signed [24:0] r_sdist;
    logic signed [23:0] r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_abs   <= r8_adist;
        r_sdist <= r8_sdist;
        r_fx    <= w_fx;
        r_fy    <= w_fy;
    end

    assign o_done            = r_done;
    assign o_abs_distance    = r_abs;
    assign o_signed_distance = r_sdist;
    assign o_foot_x          = r_fx;
    assign o_foot_y          = r_fy;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // magnitude must agree with the signed word, saturation included
    logic signed [24:0] w_neg_sd;
    logic        [23:0] w_abs_chk;

    assign w_neg_sd  = -o_signed_distance;
    assign w_abs_chk = !o_signed_distance[24] ? o_signed_distance[23:0] :
                       (o_signed_distance == 25'(ptld_pkg::SDIST_MIN)) ?
                       24'(ptld_pkg::ADIST_MAX) : w_neg_sd[23:0];

    `PTLD_ASSERT_IMP(a_abs_matches_signed, o_done, o_abs_distance == w_abs_chk)
    `PTLD_ASSERT_NXT(a_reset_quiets_done, !i_rst_n, !o_done)
    `PTLD_ASSERT_IMP(a_normal_nonzero, r5_vld, (r5_c != 32'sd0) || (r5_s != 32'sd0))

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Point to line distance core testbench
// Drives measurement words through the core in bursts with random gaps. A
// CORDIC-based predictor in the bench computes the expected distances and the
// foot of the perpendicular for each word, and every result word is checked
// against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int N_STAGES       = 16;
    // pipeline depth of the core
    localparam int PIPE_LATENCY   = N_STAGES + 9;
    // many times the longest sender gap and the slowest stretch
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_RANDOM       = 1800;

    localparam logic signed [23:0] C_MAX = 24'(ptld_pkg::COORD_MAX);
    localparam logic signed [23:0] C_MIN = 24'(ptld_pkg::COORD_MIN);

    // angle codes in 1/256 degree
    localparam logic signed [17:0] DEG_45   = 18'sd11520;
    localparam logic signed [17:0] DEG_90   = 18'sd23040;
    localparam logic signed [17:0] DEG_135  = 18'sd34560;
    localparam logic signed [17:0] DEG_180  = 18'sd46080;
    localparam logic signed [17:0] DEG_270  = 18'sd69120;
    localparam logic signed [17:0] DEG_360  = 18'sd92160;
    localparam logic signed [17:0] ANG_HIGH = 18'sd131071;
    localparam logic signed [17:0] ANG_LOW  = -18'sd131072;

    typedef struct packed {
        logic [23:0] abs_dist;
        logic [24:0] sdist;
        logic [23:0] foot_x;
        logic [23:0] foot_y;
    } t_dist_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [23:0] i_point_x;
    logic signed [23:0] i_point_y;
    logic signed [23:0] i_anchor_x;
    logic signed [23:0] i_anchor_y;
    logic signed [17:0] i_line_angle;
    logic               o_done;
    logic        [23:0] o_abs_distance;
    logic signed [24:0] o_signed_distance;
    logic signed [23:0] o_foot_x;
    logic signed [23:0] o_foot_y;

    t_dist_result pending_results[$];
    int           err_count   = 0;
    int           idle_cycles = 0;

    point_to_line_distance_core #(
        .CORDIC_STAGES(N_STAGES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_anchor_x       (i_anchor_x),
        .i_anchor_y       (i_anchor_y),
        .i_line_angle     (i_line_angle),
        .o_done           (o_done),
        .o_abs_distance   (o_abs_distance),
        .o_signed_distance(o_signed_distance),
        .o_foot_x         (o_foot_x),
        .o_foot_y         (o_foot_y)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round a Q30 product to an integer, half toward plus infinity.
    function automatic longint round_q30(longint v);
        return (v + longint'(ptld_pkg::HALF_Q30)) >>> ptld_pkg::TRIG_ONE_BITS;
    endfunction

    function automatic t_dist_result calc_distance(
        logic signed [23:0] px, logic signed [23:0] py,
        logic signed [23:0] ax, logic signed [23:0] ay,
        logic signed [17:0] ang
    );
        longint       r, x, y, z, xs, ys, d, ad, sd, fx, fy;
        logic [63:0]  num;
        logic [31:0]  bang, probe;
        int           n_iter;
        t_dist_result res;

        // reduce into one turn, then to a 32-bit binary angle, round to nearest
        r = longint'(ang) % ptld_pkg::ANG_TURN;
        if (r < 0) r += ptld_pkg::ANG_TURN;
        num  = (64'(r) << 32) + 64'(ptld_pkg::ANG_TURN / 2);
        bang = 32'(num / 64'(ptld_pkg::ANG_TURN));

        // left half plane: rotate by 180 degrees and negate sin/cos afterwards
        probe = bang + 32'h4000_0000;
        if (probe[31]) bang[31] = ~bang[31];

        z = longint'($signed(bang));
        x = longint'(ptld_pkg::CORDIC_GAIN);
        y = 0;
        n_iter = (N_STAGES > ptld_pkg::MAX_STAGES) ? ptld_pkg::MAX_STAGES : N_STAGES;
        for (int i = 0; i < n_iter; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({32'b0, ptld_pkg::ATAN_TURN[i]});
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({32'b0, ptld_pkg::ATAN_TURN[i]});
            end
        end
        if (probe[31]) begin
            x = -x;
            y = -y;
        end

        // x = cos, y = sin, normal is (-sin, cos)
        d  = round_q30(-y * (longint'(px) - longint'(ax))
                       + x * (longint'(py) - longint'(ay)));
        ad = clamp((d < 0) ? -d : d, 0, ptld_pkg::ADIST_MAX);
        sd = clamp(d, ptld_pkg::SDIST_MIN, ptld_pkg::SDIST_MAX);
        fx = clamp(longint'(px) + round_q30(y * d), ptld_pkg::COORD_MIN,
                   ptld_pkg::COORD_MAX);
        fy = clamp(longint'(py) - round_q30(x * d), ptld_pkg::COORD_MIN,
                   ptld_pkg::COORD_MAX);

        res.abs_dist = 24'(ad);
        res.sdist    = 25'(sd);
        res.foot_x   = 24'(fx);
        res.foot_y   = 24'(fy);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: drive at the falling edge, word taken at the rising edge with
    // start high and busy low. start stays high across back-to-back words.
    // ------------------------------------------------------------------------
    task automatic send_word(
        logic signed [23:0] px, logic signed [23:0] py,
        logic signed [23:0] ax, logic signed [23:0] ay,
        logic signed [17:0] ang
    );
        @(negedge i_clk);
        i_point_x    = px;
        i_point_y    = py;
        i_anchor_x   = ax;
        i_anchor_y   = ay;
        i_line_angle = ang;
        start        = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(calc_distance(px, py, ax, ay, ang));
    endtask

    task automatic pause_sender(int n_cycles);
        if (n_cycles > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (n_cycles) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: o_done marks a one-cycle result word, sampled at the
    // rising edge that ends that cycle.
    // ------------------------------------------------------------------------
    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_dist_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result word with none pending");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("abs_distance", longint'(want.abs_dist),
                            longint'(o_abs_distance));
                check_field("signed_distance", longint'($signed(want.sdist)),
                            longint'(o_signed_distance));
                check_field("foot_x", longint'($signed(want.foot_x)),
                            longint'(o_foot_x));
                check_field("foot_y", longint'($signed(want.foot_y)),
                            longint'(o_foot_y));
            end
        end
    end

    // Watchdog: any cycle with no word taken and no result counts as idle.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // zero input, full-scale coordinates, distance saturating both ways
    task automatic test_extremes();
        send_word(24'sd0, 24'sd0, 24'sd0, 24'sd0, 18'sd0);
        send_word(C_MAX, C_MAX, C_MIN, C_MIN, 18'sd0);
        send_word(C_MIN, C_MIN, C_MAX, C_MAX, DEG_90);
        send_word(C_MAX, C_MIN, C_MIN, C_MAX, DEG_45);
        send_word(C_MIN, C_MAX, C_MAX, C_MIN, DEG_45);
        pause_sender(3);
    endtask

    // quadrant edges and angles past a full turn, both signs
    task automatic test_angle_reduction();
        logic signed [17:0] angles[11] = '{
            DEG_90 - 18'sd1, DEG_90, DEG_180, DEG_270 - 18'sd1, DEG_270,
            DEG_360 - 18'sd1, DEG_360, -DEG_360, ANG_HIGH, ANG_LOW, -18'sd1
        };
        foreach (angles[i])
            send_word(24'sd25600, -24'sd12800, -24'sd3000, 24'sd7000, angles[i]);
        pause_sender(5);
    endtask

    // foot of the perpendicular pushed off each edge of the coordinate range
    task automatic test_foot_saturation();
        send_word(C_MAX, C_MIN, C_MAX, C_MAX, DEG_135);
        send_word(C_MIN, C_MAX, C_MIN, C_MIN, DEG_135);
        send_word(C_MIN, C_MAX, C_MAX, C_MAX, -DEG_45);
        send_word(C_MAX, C_MIN, C_MIN, C_MIN, -DEG_45);
        pause_sender(2);
    endtask

    // Random words in bursts. Mix of fully random geometry, points close to
    // the anchor, and angles near the quadrant edges.
    task automatic test_random_mix();
        int                 n_sent, burst_len, pick, off_x, off_y;
        logic signed [23:0] px, py, ax, ay;
        logic signed [17:0] ang;

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            burst_len = $urandom_range(1, 40);
            for (int k = 0; k < burst_len && n_sent < N_RANDOM; k++) begin
                pick = $urandom_range(0, 99);
                px   = 24'($urandom);
                py   = 24'($urandom);
                ang  = 18'($urandom);
                if (pick < 25) begin
                    off_x = int'($urandom_range(0, 8191)) - 4096;
                    off_y = int'($urandom_range(0, 8191)) - 4096;
                    ax = 24'(int'(px) + off_x);
                    ay = 24'(int'(py) + off_y);
                end else begin
                    ax = 24'($urandom);
                    ay = 24'($urandom);
                end
                if (pick >= 85)
                    ang = 18'((int'($urandom_range(0, 10)) - 5) * int'(DEG_90)
                              + int'($urandom_range(0, 8)) - 4);
                send_word(px, py, ax, ay, ang);
                n_sent++;
            end
            // a quarter of the bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_point_x    = '0;
        i_point_y    = '0;
        i_anchor_x   = '0;
        i_anchor_y   = '0;
        i_line_angle = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_angle_reduction();
        test_foot_saturation();
        test_random_mix();

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let any stray word drain out of the pipeline
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
